// ===== src/fps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fps_pkg
// Shared constants for the frame period statistics unit: filtered
// identifiers, register reset value, default histogram size, field widths.
// ----------------------------------------------------------------------------
package fps_pkg;

    // identifiers that never count as a measured frame
    localparam logic [28:0] IGNORED_ID_A = 29'd1792;
    localparam logic [28:0] IGNORED_ID_B = 29'd1793;

    // period_offset register reset value
    localparam logic [15:0] PERIOD_OFFSET_RESET = 16'd1;

    // default number of histogram bins
    localparam int DEFAULT_HIST_BINS = 1024;

    // field widths
    localparam int TIME_W  = 32;
    localparam int TOTAL_W = 64;
    localparam int BIN_CNT_W = 16;

    // divider produces one quotient bit per cycle; DIV_CNT_W sizes its step counter
    localparam int DIV_CNT_W = $clog2(TIME_W);

endpackage
`default_nettype wire

// ===== src/frame_period_statistics_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_period_statistics_unit
// Measures the period between accepted bus frames and keeps the maximum,
// its hit count, a running mean and a histogram held in block memory.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : frame_id, is_error_frame, arrival_time; beat taken when
//                    in_valid is high and in_stall is low
//   output channel : sample_number .. bin_hits; beat taken when out_valid is
//                    high and out_stall is low
//   config channel : cfg_data written to period_offset on cfg_valid & cfg_ready;
//                    write only while the block is idle
//   Error frames, identifiers 1792/1793 and the first valid frame after reset
//   give no output. A measured frame goes from acceptance to its output beat
//   in steps: the period is registered on acceptance, the histogram bin is
//   read, the bin is written back with its count incremented, the bit-serial
//   mean divider runs, and the result loads the output register.
//   One frame is in work at a time, so a new frame is taken only after the
//   last one has loaded its output beat.
//   After reset every bin of the histogram memory is swept to zero, one bin
//   per cycle, while in_stall stays high; config writes are taken.
//   A stalled output holds its beat; a finished frame then waits in the
//   unit and the input stays stalled until the output register frees up.
// ----------------------------------------------------------------------------
module frame_period_statistics_unit
    import fps_pkg::*;
#(
    parameter int HIST_BINS = DEFAULT_HIST_BINS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [15:0]          cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [28:0]          frame_id,
    input  wire logic                 is_error_frame,
    input  wire logic [TIME_W-1:0]    arrival_time,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [TIME_W-1:0]         sample_number,
    output logic [TIME_W-1:0]         current_period,
    output logic [TIME_W-1:0]         max_period,
    output logic [TIME_W-1:0]         max_hits,
    output logic [TIME_W-1:0]         mean_period,
    output logic [BIN_CNT_W-1:0]      bin_hits
);

    localparam int BIN_W = $clog2(HIST_BINS);
    localparam logic [TIME_W-1:0] LAST_BIN = TIME_W'(HIST_BINS - 1);
    localparam logic [BIN_W-1:0] LAST_ADDR = BIN_W'(HIST_BINS - 1);
    localparam logic [TIME_W-1:0] CNT_MAX = '1;
    localparam logic [BIN_CNT_W-1:0] BIN_MAX = '1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_WRITE = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]           offset_reg;
    logic                  seen_first_reg;
    logic [TIME_W-1:0]     last_time_reg;
    logic [TIME_W-1:0]     peak_period_reg;
    logic [TIME_W-1:0]     peak_hits_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TIME_W-1:0]     count_reg;
    logic [BIN_W-1:0]      clear_addr_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic                  out_valid_reg;

    logic [TIME_W-1:0]     period_reg;
    logic [TIME_W-1:0]     div_rem_reg;
    logic [TIME_W-1:0]     div_quo_reg;
    logic [BIN_CNT_W-1:0]  hits_reg;
    logic [BIN_CNT_W-1:0]  mem_rdata_reg;

    logic [TIME_W-1:0]     sample_number_reg;
    logic [TIME_W-1:0]     current_period_reg;
    logic [TIME_W-1:0]     max_period_reg;
    logic [TIME_W-1:0]     max_hits_reg;
    logic [TIME_W-1:0]     mean_period_reg;
    logic [BIN_CNT_W-1:0]  bin_hits_reg;

    logic [BIN_CNT_W-1:0]  histogram [HIST_BINS];

    logic                  in_beat;
    logic                  frame_counts;
    logic [TIME_W-1:0]     period_next;
    logic [BIN_W-1:0]      bin_addr;
    logic [BIN_W-1:0]      mem_addr;
    logic                  mem_we;
    logic                  mem_re;
    logic [BIN_CNT_W-1:0]  mem_wdata;
    logic [BIN_CNT_W-1:0]  hits_next;
    logic [TIME_W:0]       div_trial;
    logic [TIME_W:0]       div_diff;
    logic                  out_load;

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // frame filter and raw period
    assign frame_counts = !is_error_frame && (frame_id != IGNORED_ID_A)
                          && (frame_id != IGNORED_ID_B);
    assign period_next  = arrival_time - last_time_reg - {16'd0, offset_reg};

    // histogram bin of the period, large periods go to the last bin
    assign bin_addr = (period_reg >= LAST_BIN) ? LAST_ADDR : period_reg[BIN_W-1:0];

    // saturating bin increment on the read data
    assign hits_next = (mem_rdata_reg == BIN_MAX) ? mem_rdata_reg
                                                  : mem_rdata_reg + 1'b1;

    // memory port control: clear sweep, bin read, bin write back
    assign mem_addr  = (state_reg == S_CLEAR) ? clear_addr_reg : bin_addr;
    assign mem_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign mem_re    = (state_reg == S_READ);
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : hits_next;

    // divider step: shift in the next dividend bit, subtract when it fits
    assign div_trial = {div_rem_reg, div_quo_reg[TIME_W-1]};
    assign div_diff  = div_trial - {1'b0, count_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clear_addr_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_beat && frame_counts && seen_first_reg)
                    state_next = S_READ;
            end
            S_READ:  state_next = S_WRITE;
            S_WRITE: state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == '0)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // histogram memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            histogram[mem_addr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= histogram[mem_addr];
    end

    // control and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            offset_reg      <= PERIOD_OFFSET_RESET;
            seen_first_reg  <= 1'b0;
            last_time_reg   <= '0;
            peak_period_reg <= '0;
            peak_hits_reg   <= '0;
            total_reg       <= '0;
            count_reg       <= '0;
            clear_addr_reg  <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // config beat
            if (cfg_valid && cfg_ready)
                offset_reg <= cfg_data;

            // clear sweep address
            if (state_reg == S_CLEAR)
                clear_addr_reg <= clear_addr_reg + 1'b1;

            // timestamp bookkeeping
            if (in_beat && frame_counts)
            begin
                seen_first_reg <= 1'b1;
                last_time_reg  <= arrival_time;
            end

            // maximum, count and total
            if (state_reg == S_READ)
            begin
                if (period_reg > peak_period_reg)
                begin
                    peak_period_reg <= period_reg;
                    peak_hits_reg   <= TIME_W'(1);
                end
                else if (period_reg == peak_period_reg && peak_hits_reg != CNT_MAX)
                    peak_hits_reg <= peak_hits_reg + 1'b1;

                if (count_reg != CNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                    total_reg <= total_reg + {{(TOTAL_W-TIME_W){1'b0}}, period_reg};
                end
            end

            // divider iteration count
            if (state_reg == S_WRITE)
                div_cnt_reg <= '1;
            else if (state_reg == S_DIV)
                div_cnt_reg <= div_cnt_reg - 1'b1;

            // output beat register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
            period_reg <= period_next;

        if (state_reg == S_WRITE)
        begin
            hits_reg    <= hits_next;
            div_rem_reg <= total_reg[TOTAL_W-1:TIME_W];
            div_quo_reg <= total_reg[TIME_W-1:0];
        end
        else if (state_reg == S_DIV)
        begin
            div_rem_reg <= div_diff[TIME_W] ? div_trial[TIME_W-1:0] : div_diff[TIME_W-1:0];
            div_quo_reg <= {div_quo_reg[TIME_W-2:0], !div_diff[TIME_W]};
        end

        if (out_load)
        begin
            sample_number_reg  <= count_reg;
            current_period_reg <= period_reg;
            max_period_reg     <= peak_period_reg;
            max_hits_reg       <= peak_hits_reg;
            mean_period_reg    <= div_quo_reg;
            bin_hits_reg       <= hits_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_number  = sample_number_reg;
    assign current_period = current_period_reg;
    assign max_period     = max_period_reg;
    assign max_hits       = max_hits_reg;
    assign mean_period    = mean_period_reg;
    assign bin_hits       = bin_hits_reg;

    // the maximum never falls below the period it reports with
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (max_period >= current_period))
        else $error("max_period below current_period");

    // the truncated mean never exceeds the maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mean_period <= max_period))
        else $error("mean_period above max_period");

    // no count on an output beat is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample_number != '0 && max_hits != '0 && bin_hits != '0))
        else $error("zero count on output beat");

    // a rising output beat only follows the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("output beat without finished frame");

endmodule
`default_nettype wire

// ===== dv/frame_period_statistics_unit_tb.sv =====
// ----------------------------------------------------------------------------
// frame_period_statistics_unit_tb
// Self-checking bench for the frame period statistics unit. Frames go in over
// the valid/stall input channel while a scoreboard predicts every statistics
// beat: filtering of error frames and the two reserved identifiers, the first
// frame that only stores its timestamp, wrapping periods, the running
// maximum and its hit count, the truncated mean and the histogram with its
// last bin for large periods. Directed frames come first, then random
// traffic under several period offsets, with random idling on both sides.
// ----------------------------------------------------------------------------
module frame_period_statistics_unit_tb;

    import fps_pkg::*;

    localparam int BINS = DEFAULT_HIST_BINS;
    localparam int BIN_W = $clog2(BINS);
    // time to let the block settle after the last result
    localparam int SETTLE_CYCLES = 48;

    typedef struct packed {
        logic [TIME_W-1:0]    sample_number;
        logic [TIME_W-1:0]    current_period;
        logic [TIME_W-1:0]    max_period;
        logic [TIME_W-1:0]    max_hits;
        logic [TIME_W-1:0]    mean_period;
        logic [BIN_CNT_W-1:0] bin_hits;
    } period_stats_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [15:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [28:0]          frame_id;
    logic                 is_error_frame;
    logic [TIME_W-1:0]    arrival_time;
    logic                 out_valid;
    logic                 out_stall;
    logic [TIME_W-1:0]    sample_number;
    logic [TIME_W-1:0]    current_period;
    logic [TIME_W-1:0]    max_period;
    logic [TIME_W-1:0]    max_hits;
    logic [TIME_W-1:0]    mean_period;
    logic [BIN_CNT_W-1:0] bin_hits;

    // predicted state of the unit
    logic [15:0]          offset_reg;
    bit                   seen_first;
    logic [TIME_W-1:0]    last_time;
    logic [TIME_W-1:0]    peak_period;
    logic [TIME_W-1:0]    peak_hits;
    logic [TOTAL_W-1:0]   period_total;
    logic [TIME_W-1:0]    period_count;
    logic [BIN_CNT_W-1:0] bin_count [BINS];

    period_stats_t stats_due [$];

    bit          idle_on = 1'b1;
    int unsigned frames_sent;
    int unsigned frames_silent;
    int unsigned results_checked;
    int unsigned fail_count;

    frame_period_statistics_unit #(
        .HIST_BINS(BINS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_id       (frame_id),
        .is_error_frame (is_error_frame),
        .arrival_time   (arrival_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample_number  (sample_number),
        .current_period (current_period),
        .max_period     (max_period),
        .max_hits       (max_hits),
        .mean_period    (mean_period),
        .bin_hits       (bin_hits)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // gap length: none while idling is off, else mostly none or short, a few long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else if (r < 98)
            return $urandom_range(5, 40);
        else
            return $urandom_range(41, 300);
    endfunction

    // predictor: update statistics for one accepted frame
    function automatic bit advance_stats(input logic [28:0] id, input logic err,
                                         input logic [TIME_W-1:0] t,
                                         output period_stats_t res);
        logic [TIME_W-1:0] period;
        logic [BIN_W-1:0]  bin;
        res = '0;
        if (err || id == IGNORED_ID_A || id == IGNORED_ID_B)
            return 1'b0;
        if (!seen_first)
        begin
            seen_first = 1'b1;
            last_time  = t;
            return 1'b0;
        end
        period    = t - last_time - {16'd0, offset_reg};
        last_time = t;
        // running maximum and its hit count
        if (period > peak_period)
        begin
            peak_period = period;
            peak_hits   = 1;
        end
        else if (period == peak_period && peak_hits != '1)
            peak_hits = peak_hits + 1;
        // histogram, large periods fold into the last bin
        bin = (period >= 32'(BINS - 1)) ? BIN_W'(BINS - 1) : period[BIN_W-1:0];
        if (bin_count[bin] != '1)
            bin_count[bin] = bin_count[bin] + 1'b1;
        // sum and count hold once the count saturates
        if (period_count != '1)
        begin
            period_count = period_count + 1;
            period_total = period_total + {32'd0, period};
        end
        res.sample_number  = period_count;
        res.current_period = period;
        res.max_period     = peak_period;
        res.max_hits       = peak_hits;
        res.mean_period    = TIME_W'(period_total / {32'd0, period_count});
        res.bin_hits       = bin_count[bin];
        return 1'b1;
    endfunction

    // random period: near the maximum, large, around the last bin, small or spread over the bins
    function automatic logic [TIME_W-1:0] pick_period();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return peak_period;
        else if (r < 14)
            return peak_period + 1;
        else if (r < 24)
            return $urandom;
        else if (r < 32)
            return 32'($urandom_range(BINS - 4, BINS + 2));
        else if (r < 55)
            return 32'($urandom_range(0, 15));
        else
            return 32'($urandom_range(0, BINS + 76));
    endfunction

    // send one frame beat; valid stays high for a back-to-back beat
    task automatic send_frame(input logic [28:0] id, input logic err,
                              input logic [TIME_W-1:0] t);
        period_stats_t res;
        in_valid       <= 1'b1;
        frame_id       <= id;
        is_error_frame <= err;
        arrival_time   <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frames_sent++;
        if (advance_stats(id, err, t, res))
            stats_due.push_back(res);
        else
            frames_silent++;
    endtask

    // send a measured frame timed to give the wanted period
    task automatic send_at_period(input logic [28:0] id, input logic [TIME_W-1:0] p);
        send_frame(id, 1'b0, last_time + {16'd0, offset_reg} + p);
    endtask

    // random pause of the sender between beats
    task automatic idle_sender();
        int unsigned n;
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold the sender until every result has come and the unit is quiet
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write the period offset while the unit is idle
    task automatic write_period_offset(input logic [15:0] v);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        offset_reg = v;
    endtask

    // filtered frames before and after the first frame, reset offset
    task automatic test_filter_and_first();
        send_frame(29'd0, 1'b1, 32'hFFFF_FFFF);
        idle_sender();
        send_frame(IGNORED_ID_A, 1'b0, 32'h1234_5678);
        send_frame(IGNORED_ID_B, 1'b0, 32'h0000_0000);
        idle_sender();
        // first frame only stores its timestamp
        send_frame(29'h1FFF_FFFF, 1'b0, 32'hFFFF_FFF0);
        // first measured period, taken just below the timestamp wrap
        send_at_period(29'd1, 32'd5);
        send_frame(29'd0, 1'b1, 32'd0);
        send_frame(IGNORED_ID_A, 1'b1, 32'hFFFF_FFFF);
    endtask

    // maximum tracking, mean truncation, bin edges, largest period
    task automatic test_period_extremes();
        send_at_period(29'd2, 32'd5);
        idle_sender();
        send_at_period(29'd3, 32'd3);
        send_at_period(29'd4, 32'd0);
        idle_sender();
        send_at_period(29'(IGNORED_ID_A - 1), 32'(BINS - 2));
        send_at_period(29'(IGNORED_ID_B + 1), 32'(BINS - 1));
        send_at_period(29'h1555_5555, 32'(BINS));
        idle_sender();
        send_at_period(29'h0AAA_AAAA, 32'hFFFF_FFFF);
        send_at_period(29'h1000_0000, 32'hFFFF_FFFF);
        send_frame(29'h0000_0700, 1'b0, 32'd0);
        send_frame(29'h0FFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    endtask

    // offset at zero and at full scale, where short intervals wrap
    task automatic test_offset_extremes();
        write_period_offset(16'd0);
        send_frame(29'd7, 1'b0, last_time);
        send_at_period(29'd8, 32'd9);
        write_period_offset(16'hFFFF);
        send_frame(29'd9, 1'b0, last_time + 32'd10);
        send_frame(29'd10, 1'b0, last_time + 32'h0000_FFFF);
        send_at_period(29'd11, 32'd1);
    endtask

    // random traffic: mostly measured frames, some noise and filtered ids
    task automatic test_random_traffic(input logic [15:0] offset_v, input int unsigned count,
                                       input bit idling);
        int unsigned measured;
        int unsigned pick;
        logic [28:0] id;
        write_period_offset(offset_v);
        idle_on  = idling;
        measured = 0;
        while (measured < count)
        begin
            idle_sender();
            pick = $urandom_range(0, 99);
            id   = 29'($urandom);
            if (pick < 8)
                send_frame(id, 1'b1, $urandom);
            else if (pick < 12)
                send_frame(pick[0] ? IGNORED_ID_A : IGNORED_ID_B, 1'($urandom), $urandom);
            else
            begin
                if (pick < 17)
                    send_frame(id, 1'b0, $urandom);
                else
                    send_at_period(id, pick_period());
                measured++;
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                               input logic [TIME_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result checker: each output beat against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        period_stats_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (stats_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got sample %0d period %0d",
                         $time, sample_number, current_period);
                fail_count++;
            end
            else
            begin
                due = stats_due.pop_front();
                check_field("sample_number", due.sample_number, sample_number);
                check_field("current_period", due.current_period, current_period);
                check_field("max_period", due.max_period, max_period);
                check_field("max_hits", due.max_hits, max_hits);
                check_field("mean_period", due.mean_period, mean_period);
                check_field("bin_hits", {16'd0, due.bin_hits}, {16'd0, bin_hits});
                results_checked++;
            end
        end
    end

    // output stall: random runs, none while idling is off
    initial
    begin
        int unsigned n;
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            n = gap_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (1 + $urandom_range(0, 40)) @(posedge clk);
        end
    end

    // run limit
    initial
    begin
        #60_000_000;
        $display("frame_period_statistics_unit: mismatch");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        frame_id       = '0;
        is_error_frame = 1'b0;
        arrival_time   = '0;
        offset_reg     = PERIOD_OFFSET_RESET;
        seen_first     = 1'b0;
        last_time      = '0;
        peak_period    = '0;
        peak_hits      = '0;
        period_total   = '0;
        period_count   = '0;
        for (int i = 0; i < BINS; i++)
            bin_count[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_filter_and_first();
        test_period_extremes();
        test_offset_extremes();
        test_random_traffic(16'($urandom_range(0, 65535)), 350, 1'b1);
        test_random_traffic(16'd0, 350, 1'b0);
        test_random_traffic(16'hFFFF, 350, 1'b1);
        test_random_traffic(16'($urandom_range(1, 20)), 350, 1'b1);

        wait_results_drained();
        $display("run covered %0d frames, %0d of them filtered or first, %0d results checked",
                 frames_sent, frames_silent, results_checked);
        $display("offsets used: reset value, zero, full scale and random, idling on and off");
        if (fail_count == 0)
            $display("frame_period_statistics_unit: match");
        else
            $display("frame_period_statistics_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
src/fps_pkg.sv
src/frame_period_statistics_unit.sv
dv/frame_period_statistics_unit_tb.sv
